### hdl/bfe_pkg.sv
// shared types and command codes for the bfs level expansion block
package bfe_pkg;

  localparam logic [1:0] CMD_WRITE_NODE = 2'd0;
  localparam logic [1:0] CMD_WRITE_EDGE = 2'd1;
  localparam logic [1:0] CMD_EXPAND     = 2'd2;
  localparam logic [1:0] CMD_READ_NODE  = 2'd3;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [14:0] COUNT_MAX = 15'h7fff;

  typedef struct packed {
    logic [1:0]         command;
    logic [11:0]        node_index;
    logic [14:0]        edge_start;
    logic [14:0]        edge_count;
    logic               visited_in;
    logic               updating_in;
    logic signed [7:0]  cost_in;
    logic [13:0]        edge_index;
    logic [11:0]        neighbor_index;
    logic               frontier_flag;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0]  node_cost;
    logic               node_updating;
    logic               node_visited;
    logic [14:0]        marked_count;
    logic               range_error;
  } out_item_t;

  // request after classification by the front end
  typedef struct packed {
    logic [1:0] op;
    logic       node_ok;
    logic       edge_ok;
    logic       do_walk;
    in_item_t   item;
  } cmd_entry_t;

  typedef struct packed {
    logic       visited;
    logic       updating;
    logic [7:0] cost;
  } node_state_t;

endpackage

### hdl/bfe_front.sv
// front end: classifies incoming requests and queues them for the engine
module bfe_front import bfe_pkg::*; #(
  parameter int NODE_COUNT = 4096,
  parameter int EDGE_COUNT = 16384
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_data,
  output logic       q_valid,
  input  logic       q_pop,
  output cmd_entry_t q_data
);

  cmd_entry_t      q_mem [Q_DEPTH];
  cmd_entry_t      entry;
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  always_comb begin
    entry.op      = in_data.command;
    entry.node_ok = 32'(in_data.node_index) < NODE_COUNT;
    entry.edge_ok = 32'(in_data.edge_index) < EDGE_COUNT;
    entry.do_walk = (in_data.command == CMD_EXPAND) && entry.node_ok &&
                    in_data.frontier_flag;
    entry.item    = in_data;
  end

  assign full    = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_data  = q_mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/bfe_engine.sv
// back end: node and edge stores, edge walk sequencer and result register
module bfe_engine import bfe_pkg::*; #(
  parameter int NODE_COUNT = 4096,
  parameter int EDGE_COUNT = 16384
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [6:0] bfs_level,
  input  logic       q_valid,
  output logic       q_pop,
  input  cmd_entry_t q_data,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_data
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int EW = $clog2(EDGE_COUNT);
  localparam int EB = $clog2(EDGE_COUNT + 1);
  localparam int CW = (EB > 16) ? EB : 16;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_SETUP   = 3'd2;
  localparam logic [2:0] S_WALK    = 3'd3;
  localparam logic [2:0] S_FETCH   = 3'd4;
  localparam logic [2:0] S_CAPTURE = 3'd5;

  logic [29:0] range_mem [NODE_COUNT];
  node_state_t state_mem [NODE_COUNT];
  logic [11:0] edge_mem  [EDGE_COUNT];

  logic [29:0] range_rdata_r;
  node_state_t state_rdata_r;
  logic [11:0] edge_rdata_r;

  logic [2:0]  state_r, state_nxt;
  cmd_entry_t  cmd_r, cmd_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] stop_r, stop_nxt;
  logic        v1_r, v1_nxt;
  logic        v2_r, v2_nxt;
  logic [NW-1:0] tgt_r, tgt_nxt;
  logic [14:0] count_r, count_nxt;
  logic        err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [NW-1:0] node_addr;
  logic          range_we;
  logic          state_we;
  logic [NW-1:0] state_waddr;
  node_state_t   state_wdata;
  logic [NW-1:0] state_raddr;
  logic          edge_we;
  logic [EW-1:0] edge_waddr;
  logic [EW-1:0] edge_raddr;
  logic          issue0;
  logic          tgt_ok;
  logic [15:0]   sum;
  logic [CW-1:0] sum_ext;
  logic [7:0]    new_cost;

  assign node_addr  = NW'(cmd_r.item.node_index);
  assign edge_waddr = EW'(cmd_r.item.edge_index);
  assign edge_raddr = EW'(ptr_r);
  assign issue0     = ptr_r < stop_r;
  assign tgt_ok     = 32'(edge_rdata_r) < NODE_COUNT;
  assign sum        = {1'b0, range_rdata_r[29:15]} + {1'b0, range_rdata_r[14:0]};
  assign sum_ext    = CW'(sum);
  assign new_cost   = 8'({1'b0, bfs_level} + 8'd1);
  assign empty      = !out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    ptr_nxt       = ptr_r;
    stop_nxt      = stop_r;
    v1_nxt        = 1'b0;
    v2_nxt        = 1'b0;
    tgt_nxt       = NW'(edge_rdata_r);
    count_nxt     = count_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    range_we      = 1'b0;
    state_we      = 1'b0;
    state_waddr   = node_addr;
    state_wdata   = '{visited:  cmd_r.item.visited_in,
                      updating: cmd_r.item.updating_in,
                      cost:     cmd_r.item.cost_in};
    state_raddr   = node_addr;
    edge_we       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && (!out_valid_r || pop)) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        count_nxt = '0;
        err_nxt   = 1'b0;
        unique case (cmd_r.op)
          CMD_WRITE_NODE: begin
            range_we = cmd_r.node_ok;
            state_we = cmd_r.node_ok;
          end
          CMD_WRITE_EDGE: begin
            edge_we = cmd_r.edge_ok;
          end
          CMD_EXPAND, CMD_READ_NODE: begin
          end
          default: begin
          end
        endcase
        // range store is read at the node address, data is ready in setup
        state_nxt = cmd_r.do_walk ? S_SETUP : S_FETCH;
      end
      S_SETUP: begin
        ptr_nxt = CW'(range_rdata_r[29:15]);
        if (sum_ext > CW'(EDGE_COUNT)) begin
          stop_nxt = CW'(EDGE_COUNT);
          err_nxt  = 1'b1;
        end else begin
          stop_nxt = sum_ext;
        end
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // stage 0: edge read
        if (issue0) begin
          ptr_nxt = ptr_r + 1'b1;
          v1_nxt  = 1'b1;
        end
        // stage 1: target node state read
        state_raddr = NW'(edge_rdata_r);
        v2_nxt      = v1_r && tgt_ok;
        // stage 2: mark unvisited target; the walk leaves its visited bit clear
        if (v2_r && !state_rdata_r.visited) begin
          state_we    = 1'b1;
          state_waddr = tgt_r;
          state_wdata = '{visited: 1'b0, updating: 1'b1, cost: new_cost};
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
        end
        if (!issue0 && !v1_r && !v2_r) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_CAPTURE;
      end
      S_CAPTURE: begin
        out_valid_nxt = 1'b1;
        if (cmd_r.node_ok) begin
          out_data_nxt.node_cost     = state_rdata_r.cost;
          out_data_nxt.node_updating = state_rdata_r.updating;
          out_data_nxt.node_visited  = state_rdata_r.visited;
        end else begin
          out_data_nxt.node_cost     = '0;
          out_data_nxt.node_updating = 1'b0;
          out_data_nxt.node_visited  = 1'b0;
        end
        out_data_nxt.marked_count = count_r;
        out_data_nxt.range_error  = err_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (range_we) begin
      range_mem[node_addr] <= {cmd_r.item.edge_start, cmd_r.item.edge_count};
    end
    range_rdata_r <= range_mem[node_addr];
  end

  always_ff @(posedge clk) begin
    if (state_we) begin
      state_mem[state_waddr] <= state_wdata;
    end
    state_rdata_r <= state_mem[state_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= cmd_r.item.neighbor_index;
    end
    edge_rdata_r <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ptr_r      <= ptr_nxt;
    stop_r     <= stop_nxt;
    tgt_r      <= tgt_nxt;
    count_r    <= count_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/bfs_level_expand_core.sv
// top level: request queue front end, store engine and level register
// write node, write edge, read node and idle expand go through exec, fetch and capture to a result;
// expand of a frontier node goes through exec, setup, walk, fetch and capture;
// the walk takes one edge per cycle, bounded by the single read port of the edge store and node state store
// a new request is taken only once the last result is captured and the result register is free or popped
// reset: synchronous rst_n clears queue, sequencer, result valid and level; stores are not
// cleared and hold undefined data until written
module bfs_level_expand_core import bfe_pkg::*; #(
  parameter int NODE_COUNT = 4096,
  parameter int EDGE_COUNT = 16384
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata
);

  logic [6:0] bfs_level_r, bfs_level_nxt;
  logic       q_valid;
  logic       q_pop;
  cmd_entry_t q_data;

  assign bfs_level_nxt = cfg_we ? cfg_wdata : bfs_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bfs_level_r <= '0;
    end else begin
      bfs_level_r <= bfs_level_nxt;
    end
  end

  bfe_front #(
    .NODE_COUNT(NODE_COUNT),
    .EDGE_COUNT(EDGE_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data)
  );

  bfe_engine #(
    .NODE_COUNT(NODE_COUNT),
    .EDGE_COUNT(EDGE_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .bfs_level (bfs_level_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

### hdl/bfe_checker.sv
// port-level checks for the bfs level expansion block and their binding
module bfe_checker import bfe_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);

  // reset leaves the request queue not full and the result register empty
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not drained after reset");

  // the request queue only fills up right after an accepted request
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted request");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> $stable(out_data))
    else $error("waiting result changed");

endmodule

bind bfs_level_expand_core bfe_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
